@@ rtl/quadrature_odometry_assert.svh @@
// Assertion macros for the quadrature odometry block.
// Used by the top level only; relies on clk and rst in the including scope.
`ifndef QUADRATURE_ODOMETRY_ASSERT_SVH
`define QUADRATURE_ODOMETRY_ASSERT_SVH

// Clocked check, off while reset is high.
`define QO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check of a consequence in the cycle after its trigger, off in reset.
`define QO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/qodo_pkg.sv @@
// Shared types, constants and the arctangent table of the odometry block.
// No dependencies; imported by every module of the block.
package qodo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORD_IW      = $clog2(CORDIC_STEPS);
  localparam int CORD_W       = 34;
  localparam int MUL_W        = 34;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int DVD_W        = 71;
  localparam int DVS_W        = 49;
  localparam int DIV_CW       = $clog2(DVD_W);
  localparam int ADDR_W       = 4;

  localparam logic [31:0] PI_Q28       = 32'd843314857;
  localparam logic [31:0] TWO_PI_Q28   = 32'd1686629713;
  localparam logic [31:0] HALF_PI_Q28  = 32'd421657428;
  localparam logic [31:0] GAIN_Q30     = 32'd652032874;
  localparam logic [31:0] ONE_Q28      = 32'd268435456;
  localparam logic [32:0] SAT_MAG      = 33'h1_0000_0000;

  localparam logic [7:0]  BATCH_RST    = 8'd64;
  localparam logic [31:0] RADIUS_RST   = 32'd5244;
  localparam logic [31:0] BASE_RST     = 32'd29651;
  localparam logic [16:0] TICKS_RST    = 17'd4096;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_SET    = 1'b1;
  localparam logic WHEEL_RIGHT = 1'b1;
  localparam logic CHAN_B      = 1'b1;

  typedef enum logic [1:0] {
    REG_BATCH,
    REG_RADIUS,
    REG_BASE,
    REG_TICKS
  } reg_idx_t;

  typedef struct packed {
    logic               kind;
    logic               wheel;
    logic               channel;
    logic               level_a;
    logic               level_b;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } pose_t;

  // atan(2^-i) in Q28, rounded
  function automatic logic [31:0] atan_q28(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd210828714;
      5'd1:    v = 32'd124459457;
      5'd2:    v = 32'd65760959;
      5'd3:    v = 32'd33381290;
      5'd4:    v = 32'd16755422;
      5'd5:    v = 32'd8385879;
      5'd6:    v = 32'd4193963;
      5'd7:    v = 32'd2097109;
      5'd8:    v = 32'd1048571;
      5'd9:    v = 32'd524287;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd0;
      5'd31:   v = 32'd0;
      default: v = 32'd1 << (5'd28 - i);
    endcase
    return v;
  endfunction

endpackage

@@ rtl/qodo_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on qodo_pkg for operand widths.
module qodo_mul import qodo_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/qodo_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on qodo_pkg for widths.
module qodo_div import qodo_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quot,
  output logic             done
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        quot <= '0;
      end else if (busy) begin
        rem  <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        dvd  <= dvd << 1;
        quot <= {quot[DVD_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CW'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/qodo_cordic.sv @@
// Iterative CORDIC rotation giving cos and sin of a Q4.28 angle in Q30.
// Depends on qodo_pkg for the step count and arctangent table.
module qodo_cordic import qodo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [31:0]       angle,
  output logic signed [CORD_W-1:0] cos_v,
  output logic signed [CORD_W-1:0] sin_v,
  output logic                     done
);

  logic                     busy;
  logic [CORD_IW-1:0]       idx;
  logic                     neg;
  logic signed [CORD_W-1:0] cx, cy;
  logic signed [32:0]       zr;
  logic signed [32:0]       z0, z1;
  logic                     fold_neg;
  logic signed [CORD_W-1:0] sx, sy;
  logic signed [32:0]       at;

  // quadrant fold into [-pi/2, pi/2]
  always_comb begin
    z0 = 33'(angle);
    if (z0 > $signed({1'b0, PI_Q28})) begin
      z0 = z0 - $signed({1'b0, TWO_PI_Q28});
    end else if (z0 < -$signed({1'b0, PI_Q28})) begin
      z0 = z0 + $signed({1'b0, TWO_PI_Q28});
    end
    fold_neg = 1'b0;
    z1 = z0;
    if (z0 > $signed({1'b0, HALF_PI_Q28})) begin
      z1 = z0 - $signed({1'b0, PI_Q28});
      fold_neg = 1'b1;
    end else if (z0 < -$signed({1'b0, HALF_PI_Q28})) begin
      z1 = z0 + $signed({1'b0, PI_Q28});
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    sx = cy >>> idx;
    sy = cx >>> idx;
    at = $signed({1'b0, atan_q28(5'(idx))});
  end

  assign cos_v = neg ? -cx : cx;
  assign sin_v = neg ? -cy : cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        cx   <= CORD_W'(GAIN_Q30);
        cy   <= '0;
        zr   <= z1;
        neg  <= fold_neg;
      end else if (busy) begin
        if (!zr[32]) begin
          cx <= cx - sx;
          cy <= cy + sy;
          zr <= zr - at;
        end else begin
          cx <= cx + sx;
          cy <= cy - sy;
          zr <= zr + at;
        end
        idx <= idx + 1'b1;
        if (idx == CORD_IW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/quadrature_odometry.sv @@
// Top level of the quadrature odometry block: sequencer, state and APB registers.
// Depends on qodo_pkg, qodo_mul, qodo_div, qodo_cordic and the assertion header.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------
//   item     | item_valid / item_ready   | item_t (edge or set pose)
//   pose     | pose_valid / pose_ready   | pose_t (x, y, heading)
//   config   | psel, penable, pwrite     | paddr, pwdata, prdata
//
// A batch-completing edge runs the sequencer: the 71-step divider runs twice,
// with a heading wrap between the passes, and the CORDIC runs CORDIC_STEPS steps;
// the shared multiplier is used before each division and after the CORDIC.
// item_ready is high only while the sequencer idles and the pose register is
// free or being drained. Reset is synchronous and restores the configuration,
// sequencer and odometry state, not the working registers or the pose payload.
`include "quadrature_odometry_assert.svh"

module quadrature_odometry import qodo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              pose_valid,
  input  logic              pose_ready,
  output pose_t             pose,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_D,
    S_RM,
    S_LO,
    S_HI,
    S_SUM,
    S_DIV,
    S_ADD,
    S_MOD,
    S_CORD_GO,
    S_CORD,
    S_XM,
    S_YM,
    S_YS,
    S_EMIT
  } state_t;

  // configuration registers
  logic [7:0]  batch_size;
  logic [31:0] wheel_radius;
  logic [31:0] wheel_base;
  logic [16:0] ticks_per_rev;

  // odometry state
  state_t             state;
  logic signed [8:0]  left_ticks, right_ticks;
  logic [7:0]         edge_count;
  logic signed [31:0] x_position, y_position, theta_position;

  // sequencer working registers
  logic                     second;     // 0: heading pass, 1: distance pass
  logic                     mag_neg;
  logic [DVS_W-1:0]         divisor;
  logic [8:0]               a_hi;
  logic [61:0]              acc;
  logic signed [33:0]       dth, ds;
  logic                     mod_neg;
  logic [34:0]              mod_mag;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     div_start, div_done;
  logic [DVD_W-1:0]         div_dividend, div_quot;
  logic                     cord_start, cord_done;
  logic signed [CORD_W-1:0] cos_v, sin_v;

  // combinational helpers
  logic                     accept, cfg_we, dir_pos, fire, pose_free, pose_load;
  logic signed [8:0]        step;
  logic [7:0]               cnt_next;
  logic [31:0]              base_eff;
  logic [16:0]              ticks_eff;
  logic signed [9:0]        n_val;
  logic [8:0]               n_mag;
  logic [32:0]              q_sat;
  logic signed [33:0]       q_signed;
  logic signed [34:0]       th_sum;
  logic signed [38:0]       pos_sum;
  logic signed [31:0]       pos_sat;
  reg_idx_t                 cfg_idx;

  qodo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  qodo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  qodo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (theta_position),
    .cos_v (cos_v),
    .sin_v (sin_v),
    .done  (cord_done)
  );

  // ---------------------------------------------------------------------------
  // APB register file: writes land on the access phase, reads are a plain mux.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size    <= BATCH_RST;
      wheel_radius  <= RADIUS_RST;
      wheel_base    <= BASE_RST;
      ticks_per_rev <= TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BATCH:  batch_size    <= pwdata[7:0];
        REG_RADIUS: wheel_radius  <= pwdata;
        REG_BASE:   wheel_base    <= pwdata;
        REG_TICKS:  ticks_per_rev <= pwdata[16:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BATCH:  prdata = {24'd0, batch_size};
      REG_RADIUS: prdata = wheel_radius;
      REG_BASE:   prdata = wheel_base;
      REG_TICKS:  prdata = {15'd0, ticks_per_rev};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side: an edge moves one wheel count by one step. A phase A edge
  // steps forward when the levels differ, phase B the other way round, and the
  // left wheel counts with the opposite sign.
  // ---------------------------------------------------------------------------
  assign pose_free  = !pose_valid || pose_ready;
  assign item_ready = (state == S_IDLE) && pose_free;
  assign accept     = item_valid && item_ready;

  // A new pose beat is loaded this cycle: a set-pose beat or a finished batch.
  assign pose_load  = ((state == S_IDLE) && accept && (item.kind == KIND_SET)) ||
                      ((state == S_EMIT) && pose_free);

  always_comb begin
    dir_pos  = (item.level_a ^ item.level_b) ^ (item.channel == CHAN_B);
    step     = dir_pos ? 9'sd1 : -9'sd1;
    cnt_next = edge_count + 8'd1;
    fire     = cnt_next >= batch_size;    // a batch of zero fires on every edge
  end

  // A zero base or tick count divides as one.
  assign base_eff  = (wheel_base != '0) ? wheel_base : 32'd1;
  assign ticks_eff = (ticks_per_rev != '0) ? ticks_per_rev : 17'd1;

  // Tick combination for the current pass: difference for heading, sum for
  // distance.
  always_comb begin
    n_val = second ? (10'(right_ticks) + 10'(left_ticks))
                   : (10'(right_ticks) - 10'(left_ticks));
    n_mag = n_val[9] ? 9'(-n_val) : n_val[8:0];
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier operands, picked by the sequencer step. The product is
  // registered and is consumed by the next step.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state)
      S_D: begin
        // heading divisor is base * ticks; distance divisor is ticks << 28
        mul_a = second ? $signed({2'b00, ONE_Q28}) : $signed({2'b00, base_eff});
        mul_b = $signed({17'd0, ticks_eff});
      end
      S_RM: begin
        mul_a = $signed({2'b00, wheel_radius});
        mul_b = $signed({25'd0, n_mag});
      end
      S_LO: begin
        mul_a = $signed({2'b00, mul_p[31:0]});
        mul_b = $signed({2'b00, PI_Q28});
      end
      S_HI: begin
        mul_a = $signed({25'd0, a_hi});
        mul_b = $signed({2'b00, PI_Q28});
      end
      S_XM: begin
        mul_a = ds;
        mul_b = cos_v;
      end
      S_YM: begin
        mul_a = ds;
        mul_b = sin_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // radius * |n| * pi spread over two partial products, low then high word
  assign div_dividend = {mul_p[38:0], 32'd0} + {9'd0, acc};
  assign div_start    = (state == S_SUM);
  assign cord_start   = (state == S_CORD_GO);

  // Clamp the quotient to 2^32 in magnitude, then restore the sign.
  always_comb begin
    q_sat    = (div_quot > DVD_W'(SAT_MAG)) ? SAT_MAG : div_quot[32:0];
    q_signed = mag_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    th_sum   = 35'(theta_position) + 35'(dth);
  end

  // Position step: floor shift of the Q30 product, then clamp to 32 bits.
  always_comb begin
    pos_sum = (state == S_YM) ? 39'(x_position) : 39'(y_position);
    pos_sum = pos_sum + 39'(mul_p >>> 30);
    if (pos_sum > 39'sd2147483647) begin
      pos_sat = 32'sh7fff_ffff;
    end else if (pos_sum < -39'sd2147483648) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and odometry state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      second         <= 1'b0;
      left_ticks     <= '0;
      right_ticks    <= '0;
      edge_count     <= '0;
      x_position     <= '0;
      y_position     <= '0;
      theta_position <= '0;
      pose_valid     <= 1'b0;
    end else begin
      // drop the pose beat once it is taken, unless a new one replaces it
      if (pose_valid && pose_ready && !pose_load) begin
        pose_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_SET) begin
              // load the pose as given, heading unreduced, and show it
              x_position     <= item.new_x;
              y_position     <= item.new_y;
              theta_position <= item.new_heading;
              pose.pos_x     <= item.new_x;
              pose.pos_y     <= item.new_y;
              pose.heading   <= item.new_heading;
              pose_valid     <= 1'b1;
            end else begin
              if (item.wheel == WHEEL_RIGHT) begin
                right_ticks <= right_ticks + step;
              end else begin
                left_ticks <= left_ticks - step;
              end
              edge_count <= cnt_next;
              if (fire) begin
                second <= 1'b0;
                state  <= S_D;
              end
            end
          end
        end
        S_D: begin
          state <= S_RM;
        end
        S_RM: begin
          // hold the divisor and the sign of the tick combination
          divisor <= mul_p[DVS_W-1:0];
          mag_neg <= n_val[9];
          state   <= S_LO;
        end
        S_LO: begin
          a_hi  <= mul_p[40:32];
          state <= S_HI;
        end
        S_HI: begin
          acc   <= mul_p[61:0];
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (!second) begin
              dth   <= q_signed;
              state <= S_ADD;
            end else begin
              ds    <= q_signed;
              state <= S_CORD_GO;
            end
          end
        end
        S_ADD: begin
          // truncating remainder: work on the magnitude, keep the sign
          mod_neg <= th_sum[34];
          mod_mag <= th_sum[34] ? 35'(-th_sum) : 35'(th_sum);
          state   <= S_MOD;
        end
        S_MOD: begin
          if (mod_mag >= 35'(TWO_PI_Q28)) begin
            mod_mag <= mod_mag - 35'(TWO_PI_Q28);
          end else begin
            theta_position <= mod_neg ? -mod_mag[31:0] : mod_mag[31:0];
            second         <= 1'b1;
            state          <= S_D;
          end
        end
        S_CORD_GO: begin
          state <= S_CORD;
        end
        S_CORD: begin
          if (cord_done) begin
            state <= S_XM;
          end
        end
        S_XM: begin
          state <= S_YM;
        end
        S_YM: begin
          x_position <= pos_sat;
          state      <= S_YS;
        end
        S_YS: begin
          y_position  <= pos_sat;
          left_ticks  <= '0;
          right_ticks <= '0;
          edge_count  <= '0;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          // wait for the pose register to free up
          if (pose_free) begin
            pose.pos_x   <= x_position;
            pose.pos_y   <= y_position;
            pose.heading <= theta_position;
            pose_valid   <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `QO_ASSERT_NEXT(a_set_pose_shown,
    item_valid && item_ready && item.kind == KIND_SET,
    pose_valid && pose.pos_x == $past(item.new_x)
      && pose.heading == $past(item.new_heading),
    "set-pose beat not shown on the pose channel")
  `QO_ASSERT(a_div_done_in_wait, div_done |-> state == S_DIV,
    "divider finished outside its wait step")
  `QO_ASSERT(a_cord_done_in_wait, cord_done |-> state == S_CORD,
    "CORDIC finished outside its wait step")

endmodule

@@ bench/tb_quadrature_odometry.sv @@
// Testbench for the quadrature odometry block: directed and random beats,
// with a self-contained pose predictor. Depends on qodo_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_quadrature_odometry;
  import qodo_pkg::*;

  localparam longint RUN_LIMIT  = 3000000;
  localparam int     SETTLE     = 250;      // covers a batch update plus heading wrap
  localparam int     ITEM_W     = $bits(item_t);
  localparam longint PI_28      = 64'sd843314857;
  localparam longint TWO_PI_28  = 64'sd1686629713;
  localparam longint HALF_PI_28 = 64'sd421657428;
  localparam longint GAIN_30    = 64'sd652032874;
  localparam longint SAT_CAP    = 64'sd4294967296;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  item_t             item = '0;
  logic              pose_valid;
  logic              pose_ready = 1'b0;
  pose_t             pose;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  quadrature_odometry u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and the odometry state.
  logic [7:0]  batch_r;
  logic [31:0] radius_r, base_r;
  logic [16:0] ticks_r;
  int          left_cnt, right_cnt;
  logic [7:0]  edges_seen;
  longint      x_pos, y_pos, theta;
  longint unsigned arctan_q28[32];

  pose_t  pending_poses[$];
  int     errors, beats_sent, poses_seen, updates_fired, pose_loads;
  bit     calm;          // no idling on either side
  bit     hold_req;
  int     hold_cycles;
  longint cycles;

  // Quadrature phase per wheel, index into the Gray sequence {a,b}.
  logic [1:0] gray_seq[4] = '{2'b00, 2'b10, 2'b11, 2'b01};
  int         phase_idx[2];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void fill_arctan();
    longint unsigned acc, term;
    for (int i = 0; i < 32; i++) begin
      if (i == 0) begin
        arctan_q28[0] = 64'd210828714;
      end else begin
        acc = 0;
        for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
          term = (64'd1 << (62 - (2 * k + 1) * i)) / longint'(2 * k + 1);
          if (k & 1) acc -= term;
          else acc += term;
        end
        arctan_q28[i] = (acc + (64'd1 << 33)) >> 34;
      end
    end
  endfunction

  // pi*r*|n|/d truncated, capped at 2^32, then signed like n
  function automatic longint scaled_step(input longint n, input longint unsigned d);
    logic [127:0] prod, quo;
    longint unsigned mag;
    mag  = (n < 0) ? -n : n;
    prod = 128'(radius_r) * 128'(mag) * 128'(PI_28);
    quo  = prod / 128'(d);
    if (quo > 128'(SAT_CAP)) quo = 128'(SAT_CAP);
    return (n < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic void rotate(input longint z, output longint c, output longint s);
    longint cx, cy, nx;
    bit     flip;
    flip = 0;
    cx = GAIN_30;
    cy = 0;
    if (z > PI_28) z -= TWO_PI_28;
    else if (z < -PI_28) z += TWO_PI_28;
    if (z > HALF_PI_28) begin
      z -= PI_28; flip = 1;
    end else if (z < -HALF_PI_28) begin
      z += PI_28; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= longint'(arctan_q28[i]);
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += longint'(arctan_q28[i]);
      end
      cx = nx;
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void advance_pose();
    longint unsigned base_d, tick_d;
    longint d_theta, travel, c, s;
    base_d  = (base_r == 0) ? 1 : base_r;
    tick_d  = (ticks_r == 0) ? 1 : ticks_r;
    d_theta = scaled_step(right_cnt - left_cnt, base_d * tick_d);
    theta   = (theta + d_theta) % TWO_PI_28;   // remainder keeps the dividend's sign
    travel  = scaled_step(right_cnt + left_cnt, tick_d << 28);
    rotate(theta, c, s);
    x_pos = clamp32(x_pos + ((travel * c) >>> 30));
    y_pos = clamp32(y_pos + ((travel * s) >>> 30));
    left_cnt   = 0;
    right_cnt  = 0;
    edges_seen = 0;
  endfunction

  function automatic void predict_pose(input item_t it);
    int step;
    if (it.kind == KIND_SET) begin
      x_pos = it.new_x;
      y_pos = it.new_y;
      theta = it.new_heading;
      pose_loads++;
    end else begin
      step = (it.level_a ^ it.level_b) ? 1 : -1;
      if (it.channel == CHAN_B) step = -step;
      if (it.wheel == WHEEL_RIGHT) right_cnt += step;
      else left_cnt -= step;
      edges_seen++;
      if (edges_seen < batch_r) return;
      advance_pose();
      updates_fired++;
    end
    pending_poses.push_back(pose_t'{x_pos[31:0], y_pos[31:0], theta[31:0]});
  endfunction

  // Offer one beat; valid stays high on return so back-to-back beats need no gap.
  task automatic send_beat(input item_t it);
    if (!calm && $urandom_range(99) < 32) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    beats_sent++;
    predict_pose(it);
  endtask

  task automatic drop_valid();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_poses.size() != 0) @(posedge clk);
  endtask

  // Drain, let the sequencer settle, then write and read back one register.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] mask, got;
    drop_valid();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BATCH:  begin batch_r  = val[7:0];  mask = 32'h0000_00FF; end
      REG_RADIUS: begin radius_r = val;       mask = 32'hFFFF_FFFF; end
      REG_BASE:   begin base_r   = val;       mask = 32'hFFFF_FFFF; end
      default:    begin ticks_r  = val[16:0]; mask = 32'h0001_FFFF; end
    endcase
    if ((got & mask) !== (val & mask))
      flag_mismatch($sformatf("reg %s read %h, wrote %h", idx.name(), got, val));
  endtask

  task automatic apply_setting(input logic [7:0] b, input logic [31:0] r,
                               input logic [31:0] w, input logic [16:0] t);
    write_reg(REG_BATCH, b);
    write_reg(REG_RADIUS, r);
    write_reg(REG_BASE, w);
    write_reg(REG_TICKS, t);
  endtask

  // Random bits in every field of an input beat.
  function automatic item_t noise_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return item_t'(raw[ITEM_W-1:0]);
  endfunction

  function automatic item_t set_pose_beat(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] h);
    item_t it;
    it = noise_item();
    it.kind = KIND_SET;
    it.new_x = x;
    it.new_y = y;
    it.new_heading = h;
    return it;
  endfunction

  // One encoder edge: a legal Gray step in the given direction.
  function automatic item_t encoder_edge(input int w, input bit fwd);
    item_t it;
    int    from, to;
    it   = noise_item();
    from = phase_idx[w];
    to   = fwd ? (from + 1) % 4 : (from + 3) % 4;
    it.kind    = KIND_EDGE;
    it.wheel   = w[0];
    it.channel = ((fwd ? from : to) % 2) != 0;  // even-to-odd steps move phase A
    {it.level_a, it.level_b} = gray_seq[to];
    phase_idx[w] = to;
    return it;
  endfunction

  function automatic item_t random_beat(input bit fwd_bias);
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      it = set_pose_beat($urandom, $urandom, $urandom);
    end else if (pick < 80) begin
      it = encoder_edge($urandom_range(1), ($urandom_range(99) < 85) ? fwd_bias : !fwd_bias);
    end else begin
      // noisy edge: levels that need not follow the Gray order
      it = noise_item();
      it.kind = KIND_EDGE;
    end
    return it;
  endfunction

  // Check each pose beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pose_valid && pose_ready) begin
      poses_seen++;
      if (pending_poses.size() == 0) begin
        flag_mismatch($sformatf("unexpected pose %h", pose));
      end else begin
        if (pose.pos_x !== pending_poses[0].pos_x)
          flag_mismatch($sformatf("pos_x %h, want %h", pose.pos_x, pending_poses[0].pos_x));
        if (pose.pos_y !== pending_poses[0].pos_y)
          flag_mismatch($sformatf("pos_y %h, want %h", pose.pos_y, pending_poses[0].pos_y));
        if (pose.heading !== pending_poses[0].heading)
          flag_mismatch($sformatf("heading %h, want %h", pose.heading,
                                  pending_poses[0].heading));
        void'(pending_poses.pop_front());
      end
    end
  end

  // Drive the receiver: a long counted hold on request, else always ready while calm and random idling otherwise.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cycles = 800;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      pose_ready <= 1'b0;
    end else if (calm) begin
      pose_ready <= 1'b1;
    end else begin
      pose_ready <= ($urandom_range(99) >= 32);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Every field extreme on a set-pose load, then every edge level combination.
  task automatic test_field_extremes();
    send_beat(set_pose_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(set_pose_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(set_pose_beat(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
    send_beat(set_pose_beat(32'h0, 32'h0, 32'h0));
    for (int combo = 0; combo < 16; combo++) begin
      item_t it;
      it = noise_item();
      it.kind = KIND_EDGE;
      {it.wheel, it.channel, it.level_a, it.level_b} = combo[3:0];
      send_beat(it);
    end
  endtask

  // Zero and one batch sizes, heading wrap, saturation and zero divisors.
  task automatic test_special_cases();
    apply_setting(8'd0, 32'd5244, 32'd29651, 17'd4096);
    send_beat(set_pose_beat(32'h0, 32'h0, 32'h7FFF_FFFF));   // unreduced heading
    repeat (4) send_beat(encoder_edge(1, 1'b1));
    write_reg(REG_BATCH, 8'd1);
    repeat (3) send_beat(encoder_edge(0, 1'b0));
    // huge radius drives x and y into saturation
    apply_setting(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd128);
    send_beat(set_pose_beat(32'h7FFF_0000, 32'h8000_FFFF, 32'h1000_0000));
    repeat (4) send_beat(encoder_edge(1, 1'b1));
    repeat (3) send_beat(encoder_edge(0, 1'b1));
    // zero divisors are read as one
    apply_setting(8'd2, 32'd65536, 32'd0, 17'd0);
    repeat (6) send_beat(encoder_edge($urandom_range(1), 1'b1));
  endtask

  // Hold the pose side off while beats keep coming, then pause until drained.
  task automatic test_backpressure();
    apply_setting(8'd0, 32'd5244, 32'd29651, 17'd4096);
    calm = 1'b1;
    hold_req = 1'b1;
    repeat (30) send_beat(random_beat(1'b1));
    drop_valid();
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [7:0]  b_list[8]  = '{8'd64, 8'd128, 8'd1, 8'd0, 8'd255, 8'd8, 8'd16, 8'd100};
    logic [31:0] r_list[8]  = '{32'd5244, 32'd1, 32'hFFFF_FFFF, 32'd65536,
                               32'd5244, 32'd20000, 32'h0001_0000, 32'd9000};
    logic [31:0] w_list[8]  = '{32'd29651, 32'd1, 32'hFFFF_FFFF, 32'd0,
                               32'd29651, 32'd65536, 32'd300, 32'd100000};
    logic [16:0] t_list[8]  = '{17'd4096, 17'd128, 17'd65536, 17'd131071,
                               17'd0, 17'd1024, 17'd512, 17'd4096};
    bit fwd;
    for (int k = 0; k < 8; k++) begin
      r_list[4] = $urandom;
      apply_setting(b_list[k], r_list[k], w_list[k], t_list[k]);
      calm = (k == 0);
      fwd  = $urandom_range(1);
      for (int n = 0; n < 120; n++) send_beat(random_beat(fwd));
      calm = 1'b0;
    end
    drop_valid();
  endtask

  initial begin
    fill_arctan();
    batch_r    = BATCH_RST;
    radius_r   = RADIUS_RST;
    base_r     = BASE_RST;
    ticks_r    = TICKS_RST;
    left_cnt   = 0;
    right_cnt  = 0;
    edges_seen = 0;
    x_pos = 0;
    y_pos = 0;
    theta = 0;
    phase_idx = '{0, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_special_cases();
    test_backpressure();
    test_random_settings();

    drop_valid();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d beats: %0d batch updates and %0d pose loads, %0d poses checked,",
             beats_sent, updates_fired, pose_loads, poses_seen);
    $display("across batch sizes 0..255, extreme radii, zero divisors and a long stall.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
